/* rtl/dpks_pkg.sv */
package dpks_pkg;

  localparam int FEAT_LEN    = 512;
  localparam int GALLERY_MAX = 4096;
  localparam int K_MAX       = 16;

  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SCORE_W = 41;
  localparam int IDX_W   = 12;
  localparam int RANK_W  = 4;
  localparam int TOPK_W  = 5;
  localparam int CMD_W   = 2;

  localparam int POS_W  = $clog2(FEAT_LEN + 1);
  localparam int ADDR_W = (FEAT_LEN > 1) ? $clog2(FEAT_LEN) : 1;
  localparam int GCNT_W = $clog2(GALLERY_MAX + 1);
  localparam int K_W    = $clog2(K_MAX + 1);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GALLERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd2;

  localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd5;

  typedef struct packed {
    logic              valid;
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  value;
    logic              last;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [IDX_W-1:0]   index;
  } entry_t;

endpackage

/* rtl/dpks_mac.sv */
module dpks_mac (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpks_pkg::item_t item_i,
  output dpks_pkg::entry_t ins_o,
  output logic            rep_o
);

  logic [dpks_pkg::VAL_W-1:0] qmem [dpks_pkg::FEAT_LEN];

  logic [dpks_pkg::POS_W-1:0]  qpos_q, gpos_q, fill_q;
  logic [dpks_pkg::GCNT_W-1:0] gcnt_q;
  logic is_q, is_g, is_r, q_inr, g_inr;

  logic [dpks_pkg::VAL_W-1:0] rd_q, val1_q;
  logic [dpks_pkg::IDX_W-1:0] idx1_q, idx2_q;
  logic gal1_q, rep1_q, last1_q, rnk1_q, use1_q;
  logic gal2_q, rep2_q, last2_q, rnk2_q;
  logic [dpks_pkg::PROD_W-1:0]  prod2_q;
  logic [dpks_pkg::SCORE_W-1:0] acc_q, sat;
  logic [dpks_pkg::SCORE_W:0]   sum;
  dpks_pkg::entry_t ins_q;
  logic rep_q;

  assign is_q  = item_i.valid && (item_i.cmd == dpks_pkg::CMD_QUERY);
  assign is_g  = item_i.valid && (item_i.cmd == dpks_pkg::CMD_GALLERY);
  assign is_r  = item_i.valid && (item_i.cmd == dpks_pkg::CMD_REPORT);
  assign q_inr = qpos_q < dpks_pkg::POS_W'(dpks_pkg::FEAT_LEN);
  assign g_inr = gpos_q < dpks_pkg::POS_W'(dpks_pkg::FEAT_LEN);

  // query store, entries at or above the fill mark read as zero
  always_ff @(posedge clk_i) begin
    if (is_q && q_inr) begin
      qmem[qpos_q[dpks_pkg::ADDR_W-1:0]] <= item_i.value;
    end
    rd_q   <= qmem[gpos_q[dpks_pkg::ADDR_W-1:0]];
    val1_q <= item_i.value;
    idx1_q <= dpks_pkg::IDX_W'(gcnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q  <= '0;
      gpos_q  <= '0;
      fill_q  <= '0;
      gcnt_q  <= '0;
      gal1_q  <= 1'b0;
      rep1_q  <= 1'b0;
      last1_q <= 1'b0;
      rnk1_q  <= 1'b0;
      use1_q  <= 1'b0;
    end else begin
      if (is_q) begin
        if (item_i.last) begin
          qpos_q <= '0;
        end else if (q_inr) begin
          qpos_q <= qpos_q + 1'b1;
        end
        if (q_inr && (qpos_q >= fill_q)) begin
          fill_q <= qpos_q + 1'b1;
        end
      end
      if (is_r) begin
        gpos_q <= '0;
        gcnt_q <= '0;
      end else if (is_g) begin
        if (item_i.last) begin
          gpos_q <= '0;
          if (gcnt_q < dpks_pkg::GCNT_W'(dpks_pkg::GALLERY_MAX)) begin
            gcnt_q <= gcnt_q + 1'b1;
          end
        end else if (g_inr) begin
          gpos_q <= gpos_q + 1'b1;
        end
      end
      gal1_q  <= is_g;
      rep1_q  <= is_r;
      last1_q <= item_i.last;
      rnk1_q  <= gcnt_q < dpks_pkg::GCNT_W'(dpks_pkg::GALLERY_MAX);
      use1_q  <= is_g && g_inr && (gpos_q < fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod2_q <= use1_q ? (rd_q * val1_q) : '0;
    idx2_q  <= idx1_q;
  end

  assign sum = {1'b0, acc_q} + (dpks_pkg::SCORE_W + 1)'(prod2_q);
  assign sat = sum[dpks_pkg::SCORE_W] ? '1 : sum[dpks_pkg::SCORE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gal2_q  <= 1'b0;
      rep2_q  <= 1'b0;
      last2_q <= 1'b0;
      rnk2_q  <= 1'b0;
      acc_q   <= '0;
      ins_q   <= '0;
      rep_q   <= 1'b0;
    end else begin
      gal2_q  <= gal1_q;
      rep2_q  <= rep1_q;
      last2_q <= last1_q;
      rnk2_q  <= rnk1_q;
      if (rep2_q) begin
        acc_q <= '0;
      end else if (gal2_q) begin
        acc_q <= last2_q ? '0 : sat;
      end
      ins_q.valid <= gal2_q && last2_q && rnk2_q;
      ins_q.score <= sat;
      ins_q.index <= idx2_q;
      rep_q       <= rep2_q;
    end
  end

  assign ins_o = ins_q;
  assign rep_o = rep_q;

endmodule

/* rtl/dpks_cell.sv */
module dpks_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dpks_pkg::entry_t ins_i,
  input  dpks_pkg::entry_t left_i,
  input  logic             left_ge_i,
  input  dpks_pkg::entry_t right_i,
  input  logic             shift_i,
  input  logic             clear_i,
  output dpks_pkg::entry_t ent_o,
  output logic             ge_o
);

  dpks_pkg::entry_t ent_q;

  // equal score stays ahead of the newcomer
  assign ge_o = ent_q.valid && (ent_q.score >= ins_i.score);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (clear_i) begin
      ent_q.valid <= 1'b0;
    end else if (shift_i) begin
      ent_q <= right_i;
    end else if (ins_i.valid && !ge_o) begin
      ent_q <= left_ge_i ? ins_i : left_i;
    end
  end

  assign ent_o = ent_q;

endmodule

/* rtl/dpks_rank.sv */
module dpks_rank (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpks_pkg::entry_t                    ins_i,
  input  logic                                rep_i,
  input  logic [dpks_pkg::TOPK_W-1:0]         top_k_i,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [dpks_pkg::OUT_TDATA_W-1:0]    m_data_o,
  output logic                                m_last_o,
  output logic                                m_user_o
);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_e;

  state_e state_q;
  logic [dpks_pkg::K_W-1:0]    rem_q, k_eff;
  logic [dpks_pkg::RANK_W-1:0] rank_q;
  logic                        m_valid_q, m_last_q, m_user_q;
  logic [dpks_pkg::OUT_TDATA_W-1:0] m_data_q;

  dpks_pkg::entry_t ent   [dpks_pkg::K_MAX];
  dpks_pkg::entry_t left  [dpks_pkg::K_MAX];
  dpks_pkg::entry_t right [dpks_pkg::K_MAX];
  logic [dpks_pkg::K_MAX-1:0] ge, left_ge;
  logic load, last_sel;

  always_comb begin
    if (top_k_i == '0) begin
      k_eff = dpks_pkg::K_W'(1);
    end else if (int'(top_k_i) > dpks_pkg::K_MAX) begin
      k_eff = dpks_pkg::K_W'(dpks_pkg::K_MAX);
    end else begin
      k_eff = dpks_pkg::K_W'(top_k_i);
    end
  end

  assign load     = (state_q == ST_DRAIN) && (!m_valid_q || m_ready_i);
  assign last_sel = (rem_q == dpks_pkg::K_W'(1)) || !right[0].valid;

  for (genvar i = 0; i < dpks_pkg::K_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i]    = '0;
      assign left_ge[i] = 1'b1;
    end else begin : g_body
      assign left[i]    = ent[i-1];
      assign left_ge[i] = ge[i-1];
    end
    if (i == dpks_pkg::K_MAX - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_mid
      assign right[i] = ent[i+1];
    end

    dpks_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_i     (ins_i),
      .left_i    (left[i]),
      .left_ge_i (left_ge[i]),
      .right_i   (right[i]),
      .shift_i   (load),
      .clear_i   (load && last_sel),
      .ent_o     (ent[i]),
      .ge_o      (ge[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rem_q     <= '0;
      rank_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
      m_user_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (rep_i && !ent[0].valid) begin
            m_valid_q <= 1'b1;
            m_data_q  <= '0;
            m_last_q  <= 1'b1;
            m_user_q  <= 1'b1;
          end else begin
            if (m_ready_i) begin
              m_valid_q <= 1'b0;
            end
            if (rep_i) begin
              state_q <= ST_DRAIN;
              rem_q   <= k_eff;
              rank_q  <= '0;
            end
          end
        end
        ST_DRAIN: begin
          if (load) begin
            m_valid_q <= 1'b1;
            m_data_q  <= dpks_pkg::OUT_TDATA_W'({rank_q, ent[0].score, ent[0].index});
            m_last_q  <= last_sel;
            m_user_q  <= 1'b0;
            rank_q    <= rank_q + 1'b1;
            rem_q     <= rem_q - 1'b1;
            if (last_sel) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;
  assign m_user_o  = m_user_q;

endmodule

/* rtl/dot_product_top_k_search_core.sv */
// top-k inner product search
// s_axis carries one feature element per transaction: tuser selects query
// load, gallery element or report; tlast closes a query or gallery vector.
// query elements fill the query store, gallery elements are multiplied by the
// matching query element and summed, and each finished gallery vector is
// inserted into a sorted row of k_max cells (ties keep the earlier index).
// element transactions are taken every cycle while s_axis_tready is high; a vector's
// score reaches the ranking row through the read, product and insertion registers.
// a report transaction is followed by min(top_k, ranked) results on m_axis (top_k
// of 0 counts as 1, above k_max as k_max), best first, or one result with tuser set
// when nothing was ranked; tlast marks the final one. the report follows the elements
// through the pipeline; results then go one per cycle while m_axis_tready is high.
// s_axis_tready is low from a report until its final result is taken, so a
// stalled receiver holds the input side for that time; the ranking row drains
// into the output register only as results are taken.
// cfg_we_i writes top_k (reset 5); the user must keep it used only while the block is idle,
// which the block itself does not enforce. reset clears all counters, the ranking and the
// query store fill mark; a query element never written reads as zero.
module dot_product_top_k_search_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dpks_pkg::TOPK_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dpks_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // element_value
  input  logic                               s_axis_tlast,
  input  logic [dpks_pkg::CMD_W-1:0]         s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dpks_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // gallery_index, score, rank
  output logic                               m_axis_tlast,
  output logic                               m_axis_tuser   // empty_res
);

  logic [dpks_pkg::TOPK_W-1:0] top_k_q;
  logic             pend_q, s_acc, m_done;
  dpks_pkg::item_t  item;
  dpks_pkg::entry_t ins;
  logic             rep;

  assign s_axis_tready = !pend_q;
  assign s_acc         = s_axis_tvalid && !pend_q;
  assign m_done        = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  assign item.valid = s_acc;
  assign item.cmd   = s_axis_tuser;
  assign item.value = s_axis_tdata;
  assign item.last  = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q <= dpks_pkg::TOPK_RESET;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        top_k_q <= cfg_wdata_i;
      end
      if (s_acc && (s_axis_tuser == dpks_pkg::CMD_REPORT)) begin
        pend_q <= 1'b1;
      end else if (m_done) begin
        pend_q <= 1'b0;
      end
    end
  end

  dpks_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .ins_o  (ins),
    .rep_o  (rep)
  );

  dpks_rank u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (ins),
    .rep_i     (rep),
    .top_k_i   (top_k_q),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_user_o  (m_axis_tuser)
  );

endmodule

/* sim/dot_product_top_k_search_core_checker.sv */
module dot_product_top_k_search_core_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpks_pkg::TOPK_W-1:0]      cfg_wdata_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [dpks_pkg::IN_TDATA_W-1:0]  s_tdata_i,   // element_value
  input  logic                             s_tlast_i,
  input  logic [dpks_pkg::CMD_W-1:0]       s_tuser_i,   // cmd
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [dpks_pkg::OUT_TDATA_W-1:0] m_tdata_i,   // gallery_index, score, rank
  input  logic                             m_tlast_i,
  input  logic                             m_tuser_i,   // empty_res
  output int                               mismatch_count_o,
  output int                               pending_results_o
);

  localparam int FIFO_DEPTH = 64;

  typedef struct packed {
    logic [dpks_pkg::IDX_W-1:0]   index;
    logic [dpks_pkg::SCORE_W-1:0] score;
    logic [dpks_pkg::RANK_W-1:0]  rank;
    logic                         last_result;
    logic                         empty_res;
  } ranked_result_t;

  localparam logic [dpks_pkg::SCORE_W-1:0] SCORE_SAT = '1;

  logic [dpks_pkg::VAL_W-1:0]   query_mem [dpks_pkg::FEAT_LEN];
  logic [dpks_pkg::POS_W-1:0]   query_pos;
  logic [dpks_pkg::POS_W-1:0]   gallery_pos;
  logic [dpks_pkg::SCORE_W-1:0] dot_sum;
  logic [dpks_pkg::GCNT_W-1:0]  gallery_seen;
  logic [dpks_pkg::SCORE_W-1:0] best_score [dpks_pkg::K_MAX];
  logic [dpks_pkg::IDX_W-1:0]   best_index [dpks_pkg::K_MAX];
  logic [dpks_pkg::K_W-1:0]     ranked_n;
  logic [dpks_pkg::TOPK_W-1:0]  top_k;
  ranked_result_t               expected_fifo [FIFO_DEPTH];
  int                           fifo_wr = 0;
  int                           fifo_rd = 0;
  int                           mismatches = 0;

  function automatic void post_expected(input ranked_result_t r);
    expected_fifo[fifo_wr % FIFO_DEPTH] = r;
    fifo_wr++;
  endfunction

  // sorted insertion, equal scores stay behind the earlier index
  function automatic void rank_insert(input logic [dpks_pkg::SCORE_W-1:0] sc,
                                      input logic [dpks_pkg::IDX_W-1:0] idx);
    int pos;
    int i;
    pos = 0;
    while (pos < ranked_n && best_score[pos] >= sc) pos++;
    if (pos >= dpks_pkg::K_MAX) return;
    i = (ranked_n < dpks_pkg::K_MAX) ? int'(ranked_n) : dpks_pkg::K_MAX - 1;
    while (i > pos) begin
      best_score[i] = best_score[i-1];
      best_index[i] = best_index[i-1];
      i--;
    end
    best_score[pos] = sc;
    best_index[pos] = idx;
    if (ranked_n < dpks_pkg::K_MAX) ranked_n++;
  endfunction

  function automatic void take_element(input logic [dpks_pkg::CMD_W-1:0] cmd,
                                       input logic [dpks_pkg::VAL_W-1:0] val,
                                       input logic is_last);
    logic [dpks_pkg::SCORE_W:0] sum;
    ranked_result_t             r;
    int                         k;
    int                         n;
    int                         i;
    case (cmd)
      dpks_pkg::CMD_QUERY: begin
        if (query_pos < dpks_pkg::FEAT_LEN) begin
          query_mem[query_pos[dpks_pkg::ADDR_W-1:0]] = val;
          query_pos++;
        end
        if (is_last) query_pos = '0;
      end
      dpks_pkg::CMD_GALLERY: begin
        if (gallery_pos < dpks_pkg::FEAT_LEN) begin
          sum = dot_sum + val * query_mem[gallery_pos[dpks_pkg::ADDR_W-1:0]];
          dot_sum = (sum > SCORE_SAT) ? SCORE_SAT : sum[dpks_pkg::SCORE_W-1:0];
          gallery_pos++;
        end
        if (is_last) begin
          if (gallery_seen < dpks_pkg::GALLERY_MAX) begin
            rank_insert(dot_sum, gallery_seen[dpks_pkg::IDX_W-1:0]);
            gallery_seen++;
          end
          dot_sum = '0;
          gallery_pos = '0;
        end
      end
      dpks_pkg::CMD_REPORT: begin
        k = top_k;
        if (k == 0) k = 1;
        if (k > dpks_pkg::K_MAX) k = dpks_pkg::K_MAX;
        n = (ranked_n < k) ? int'(ranked_n) : k;
        if (n == 0) begin
          r = '0;
          r.last_result = 1'b1;
          r.empty_res = 1'b1;
          post_expected(r);
        end else begin
          for (i = 0; i < n; i++) begin
            r.index = best_index[i];
            r.score = best_score[i];
            r.rank = dpks_pkg::RANK_W'(i);
            r.last_result = (i == n - 1);
            r.empty_res = 1'b0;
            post_expected(r);
          end
        end
        ranked_n = '0;
        gallery_seen = '0;
        gallery_pos = '0;
        dot_sum = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    ranked_result_t want;
    ranked_result_t got;
    got.index = m_tdata_i[dpks_pkg::IDX_W-1:0];
    got.score = m_tdata_i[dpks_pkg::IDX_W +: dpks_pkg::SCORE_W];
    got.rank = m_tdata_i[dpks_pkg::IDX_W+dpks_pkg::SCORE_W +: dpks_pkg::RANK_W];
    got.last_result = m_tlast_i;
    got.empty_res = m_tuser_i;
    if (fifo_wr == fifo_rd) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: idx %0d score %h rank %0d last %0b empty %0b",
                 got.index, got.score, got.rank, got.last_result, got.empty_res);
      return;
    end
    want = expected_fifo[fifo_rd % FIFO_DEPTH];
    fifo_rd++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: exp idx %0d score %h rank %0d last %0b empty %0b",
                 want.index, want.score, want.rank, want.last_result, want.empty_res);
        $display("          got idx %0d score %h rank %0d last %0b empty %0b",
                 got.index, got.score, got.rank, got.last_result, got.empty_res);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpks_pkg::FEAT_LEN; i++) query_mem[i] = '0;
      for (int i = 0; i < dpks_pkg::K_MAX; i++) begin
        best_score[i] = '0;
        best_index[i] = '0;
      end
      query_pos = '0;
      gallery_pos = '0;
      dot_sum = '0;
      gallery_seen = '0;
      ranked_n = '0;
      top_k = dpks_pkg::TOPK_RESET;
      fifo_wr = 0;
      fifo_rd = 0;
      mismatch_count_o <= mismatches;
      pending_results_o <= 0;
    end else begin
      if (cfg_we_i) top_k = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i)
        take_element(s_tuser_i, s_tdata_i[dpks_pkg::VAL_W-1:0], s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_result();
      mismatch_count_o <= mismatches;
      pending_results_o <= fifo_wr - fifo_rd;
    end
  end

endmodule

/* sim/dot_product_top_k_search_core_tb.sv */
module dot_product_top_k_search_core_tb;

  localparam logic [dpks_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [dpks_pkg::TOPK_W-1:0]      cfg_wdata_i = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [dpks_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // element_value
  logic                             s_axis_tlast = 1'b0;
  logic [dpks_pkg::CMD_W-1:0]       s_axis_tuser = dpks_pkg::CMD_QUERY;   // cmd
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [dpks_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // gallery_index, score, rank
  logic                             m_axis_tlast;
  logic                             m_axis_tuser;   // empty_res

  int mismatch_count;
  int pending_results;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int ready_pct = 100;

  logic [dpks_pkg::TOPK_W-1:0] top_k_plan [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5};

  dot_product_top_k_search_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  dot_product_top_k_search_core_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tlast_i        (s_axis_tlast),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .m_tuser_i        (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_results_o(pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random duty cycle, long hold on request
  always @(negedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 80;
        2: ready_pct = 50;
        default: ready_pct = 20;
      endcase
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [dpks_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return dpks_pkg::VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_element(input logic [dpks_pkg::CMD_W-1:0] cmd,
                              input logic [dpks_pkg::VAL_W-1:0] val,
                              input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= val;
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_vector(input logic [dpks_pkg::CMD_W-1:0] cmd, input int len);
    int i;
    for (i = 0; i < len; i++) send_element(cmd, pick_value(), i == len - 1);
  endtask

  task automatic quiesce_and_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_top_k(input logic [dpks_pkg::TOPK_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_traffic(input int n_items);
    int sent;
    int len;
    int sel;
    int i;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        len = $urandom_range(1, 6);
        send_vector(dpks_pkg::CMD_QUERY, len);
        sent += len;
      end else if (sel < 72) begin
        len = $urandom_range(1, 6);
        send_vector(dpks_pkg::CMD_GALLERY, len);
        sent += len;
      end else if (sel < 84) begin
        send_element(dpks_pkg::CMD_REPORT, pick_value(), 1'($urandom_range(0, 1)));
        sent++;
      end else if (sel < 92) begin
        send_element(CMD_UNUSED, pick_value(), 1'($urandom_range(0, 1)));
      end else begin
        // partial gallery vector, usually cut short by a later report
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) send_element(dpks_pkg::CMD_GALLERY, pick_value(), 1'b0);
        sent += len;
      end
    end
  endtask

  initial begin
    int p;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty report, ties, short vectors, unused command, dropped partial vector
    send_element(dpks_pkg::CMD_REPORT, 16'h0000, 1'b0);
    send_element(dpks_pkg::CMD_QUERY, 16'hFFFF, 1'b0);
    send_element(dpks_pkg::CMD_QUERY, 16'h0000, 1'b0);
    send_element(dpks_pkg::CMD_QUERY, 16'h8000, 1'b0);
    send_element(dpks_pkg::CMD_QUERY, 16'h0001, 1'b1);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0001, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0000, 1'b1);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0001, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0000, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b1);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0001, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0000, 1'b1);
    send_element(dpks_pkg::CMD_GALLERY, 16'hFFFF, 1'b1);
    send_element(CMD_UNUSED, 16'hFFFF, 1'b1);
    send_element(dpks_pkg::CMD_REPORT, 16'hFFFF, 1'b1);
    send_element(dpks_pkg::CMD_GALLERY, 16'h8000, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h8000, 1'b0);
    send_element(dpks_pkg::CMD_REPORT, 16'h0000, 1'b0);
    send_element(dpks_pkg::CMD_GALLERY, 16'h0001, 1'b1);
    send_element(dpks_pkg::CMD_REPORT, 16'h0000, 1'b0);
    quiesce_and_drain();

    for (p = 0; p < 6; p++) begin
      write_top_k(top_k_plan[p]);
      random_traffic(12);
      quiesce_and_drain();
    end

    // full ranking, receiver held off while further input waits on s_axis_tready
    write_top_k(5'd16);
    send_element(dpks_pkg::CMD_QUERY, 16'hC001, 1'b1);
    repeat (18) send_vector(dpks_pkg::CMD_GALLERY, 1);
    hold_requests++;
    send_element(dpks_pkg::CMD_REPORT, 16'h0000, 1'b0);
    repeat (4) send_vector(dpks_pkg::CMD_GALLERY, 1);
    send_element(dpks_pkg::CMD_REPORT, 16'h0000, 1'b0);
    quiesce_and_drain();

    write_top_k(dpks_pkg::TOPK_W'($urandom_range(1, 16)));
    random_traffic(12);
    quiesce_and_drain();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
